>>> src/hex_cell_isolevel_edge_crossings_top_defines.svh
// Assertion macros shared by the edge crossing block.
`ifndef HEX_CELL_ISOLEVEL_EDGE_CROSSINGS_TOP_DEFINES_SVH
`define HEX_CELL_ISOLEVEL_EDGE_CROSSINGS_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define HCIC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define HCIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/hcic_pkg.sv
// Types, constants and helper functions of the edge crossing block.
`timescale 1ns / 1ps
package hcic_pkg;

  localparam int VAL_W       = 16;
  localparam int DIST_W      = 16;
  localparam int SUM_W       = 17;
  localparam int FRAC_W      = 17;
  localparam int CORNER_W    = 3;
  localparam int NUM_CORNERS = 8;
  localparam int NUM_EDGES   = 12;
  localparam int EDGE_W      = 4;
  localparam int MAX_HITS    = 6;
  localparam int HIT_CNT_W   = 3;
  localparam int QUEUE_DEPTH_DEF = 4;

  typedef struct packed {
    logic signed [VAL_W-1:0] iso_level;
    logic signed [VAL_W-1:0] corner_value_0;
    logic signed [VAL_W-1:0] corner_value_1;
    logic signed [VAL_W-1:0] corner_value_2;
    logic signed [VAL_W-1:0] corner_value_3;
    logic signed [VAL_W-1:0] corner_value_4;
    logic signed [VAL_W-1:0] corner_value_5;
    logic signed [VAL_W-1:0] corner_value_6;
    logic signed [VAL_W-1:0] corner_value_7;
  } cell_item_t;

  typedef struct packed {
    logic                hit;
    logic [CORNER_W-1:0] first_corner;
    logic [CORNER_W-1:0] second_corner;
    logic [FRAC_W-1:0]   edge_fraction;
    logic                last;
  } edge_result_t;

  // Metadata that rides along the divider stages.
  typedef struct packed {
    logic                hit;
    logic [CORNER_W-1:0] first_corner;
    logic [CORNER_W-1:0] second_corner;
    logic                last;
  } job_meta_t;

  // One queued edge: what the back end needs to form the fraction.
  typedef struct packed {
    job_meta_t         meta;
    logic [DIST_W-1:0] dist_a;
    logic [SUM_W-1:0]  dist_sum;
  } edge_job_t;

  function automatic logic [CORNER_W-1:0] edge_first(input logic [EDGE_W-1:0] e);
    logic [CORNER_W-1:0] c;
    case (e)
      4'd0:    c = 3'd0;
      4'd1:    c = 3'd1;
      4'd2:    c = 3'd3;
      4'd3:    c = 3'd2;
      4'd4:    c = 3'd4;
      4'd5:    c = 3'd5;
      4'd6:    c = 3'd7;
      4'd7:    c = 3'd6;
      4'd8:    c = 3'd0;
      4'd9:    c = 3'd1;
      4'd10:   c = 3'd2;
      4'd11:   c = 3'd3;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

  function automatic logic [CORNER_W-1:0] edge_second(input logic [EDGE_W-1:0] e);
    logic [CORNER_W-1:0] c;
    case (e)
      4'd0:    c = 3'd1;
      4'd1:    c = 3'd3;
      4'd2:    c = 3'd2;
      4'd3:    c = 3'd0;
      4'd4:    c = 3'd5;
      4'd5:    c = 3'd7;
      4'd6:    c = 3'd6;
      4'd7:    c = 3'd4;
      4'd8:    c = 3'd4;
      4'd9:    c = 3'd5;
      4'd10:   c = 3'd6;
      4'd11:   c = 3'd7;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

  // Distance |level - v|; fits 16 bits unsigned.
  function automatic logic [DIST_W-1:0] dist_of(input logic signed [VAL_W-1:0] lvl,
                                                input logic signed [VAL_W-1:0] v);
    logic signed [VAL_W:0] d;
    d = (v >= lvl) ? ({v[VAL_W-1], v} - {lvl[VAL_W-1], lvl})
                   : ({lvl[VAL_W-1], lvl} - {v[VAL_W-1], v});
    return d[DIST_W-1:0];
  endfunction

  // Lowest set bit of the pending edge mask.
  function automatic logic [EDGE_W-1:0] first_edge(input logic [NUM_EDGES-1:0] m);
    logic [EDGE_W-1:0] idx;
    idx = '0;
    for (int i = NUM_EDGES - 1; i >= 0; i--) begin
      if (m[i]) idx = EDGE_W'(i);
    end
    return idx;
  endfunction

  // One restoring division step: {quotient bit, new remainder}.
  function automatic logic [SUM_W:0] div_step(input logic [SUM_W-1:0] r,
                                              input logic [SUM_W-1:0] d);
    logic [SUM_W:0] t;
    logic [SUM_W:0] diff;
    t    = {r, 1'b0};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) return {1'b1, diff[SUM_W-1:0]};
    else return {1'b0, t[SUM_W-1:0]};
  endfunction

endpackage

>>> src/hcic_front.sv
// Front end: accept a cell, classify its edges, issue crossed edges or one empty job, one per cycle unless full.
`timescale 1ns / 1ps
module hcic_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  hcic_pkg::cell_item_t item,
  output logic                push,
  output hcic_pkg::edge_job_t push_job,
  input  logic                full
);
  import hcic_pkg::*;

  logic                  busy;
  logic                  nohit;
  logic [NUM_EDGES-1:0]  mask;
  logic [HIT_CNT_W-1:0]  cnt;
  logic [DIST_W-1:0]     edge_da  [NUM_EDGES];
  logic [SUM_W-1:0]      edge_sum [NUM_EDGES];

  logic [VAL_W-1:0]      corner      [NUM_CORNERS];
  logic [DIST_W-1:0]     corner_dist [NUM_CORNERS];
  logic [NUM_CORNERS-1:0] up;
  logic [NUM_EDGES-1:0]  mask_in;
  logic [EDGE_W-1:0]     idx;
  logic [NUM_EDGES-1:0]  mask_rest;
  logic                  is_last;
  logic                  accept;

  always_comb begin
    corner[0] = item.corner_value_0;
    corner[1] = item.corner_value_1;
    corner[2] = item.corner_value_2;
    corner[3] = item.corner_value_3;
    corner[4] = item.corner_value_4;
    corner[5] = item.corner_value_5;
    corner[6] = item.corner_value_6;
    corner[7] = item.corner_value_7;
    for (int c = 0; c < NUM_CORNERS; c++) begin
      up[c]          = $signed(corner[c]) >= item.iso_level;
      corner_dist[c] = dist_of(item.iso_level, corner[c]);
    end
    for (int e = 0; e < NUM_EDGES; e++) begin
      mask_in[e] = up[edge_first(EDGE_W'(e))] ^ up[edge_second(EDGE_W'(e))];
    end
  end

  assign idx       = first_edge(mask);
  assign mask_rest = mask & ~(NUM_EDGES'(1) << idx);
  assign is_last   = nohit || (mask_rest == '0) || (cnt == HIT_CNT_W'(MAX_HITS - 1));
  assign push      = busy && !full;
  assign item_stall = busy && !(push && is_last);
  assign accept    = item_valid && !item_stall;

  always_comb begin
    push_job.meta.hit           = !nohit;
    push_job.meta.first_corner  = nohit ? '0 : edge_first(idx);
    push_job.meta.second_corner = nohit ? '0 : edge_second(idx);
    push_job.meta.last          = is_last;
    push_job.dist_a             = nohit ? '0 : edge_da[idx];
    // A sum of one with zero distance divides to zero for the no-crossing beat.
    push_job.dist_sum           = nohit ? SUM_W'(1) : edge_sum[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (push && is_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mask  <= mask_in;
      cnt   <= '0;
      nohit <= (mask_in == '0);
      for (int e = 0; e < NUM_EDGES; e++) begin
        edge_da[e]  <= corner_dist[edge_first(EDGE_W'(e))];
        edge_sum[e] <= {1'b0, corner_dist[edge_first(EDGE_W'(e))]}
                     + {1'b0, corner_dist[edge_second(EDGE_W'(e))]};
      end
    end else if (push) begin
      mask <= mask_rest;
      cnt  <= cnt + HIT_CNT_W'(1);
    end
  end

endmodule

>>> src/hcic_queue.sv
// Short queue of edge jobs between front and back end.
`timescale 1ns / 1ps
module hcic_queue #(
  parameter int DEPTH = hcic_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  hcic_pkg::edge_job_t push_job,
  output logic                full,
  input  logic                pop,
  output hcic_pkg::edge_job_t pop_job,
  output logic                empty
);
  import hcic_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  edge_job_t         slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;

  assign full    = (fill == CNT_W'(DEPTH));
  assign empty   = (fill == '0);
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push && !full, pop && !empty})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) slots[wr_ptr] <= push_job;
  end

endmodule

>>> src/hcic_back.sv
// Back end: pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module hcic_back (
  input  logic                  clk,
  input  logic                  rst,
  input  hcic_pkg::edge_job_t   pop_job,
  input  logic                  empty,
  output logic                  pop,
  output logic                  result_valid,
  input  logic                  result_stall,
  output hcic_pkg::edge_result_t result
);
  import hcic_pkg::*;

  localparam int NSTG = FRAC_W;

  logic [NSTG-1:0]   vld;
  logic [SUM_W-1:0]  rem  [NSTG];
  logic [SUM_W-1:0]  dvs  [NSTG];
  logic [FRAC_W-1:0] quo  [NSTG];
  job_meta_t         meta [NSTG];
  logic [SUM_W:0]    step [NSTG];
  logic              adv;
  logic              top_bit;

  // The whole pipe holds while the output beat waits.
  assign adv     = !(vld[NSTG-1] && result_stall);
  assign pop     = adv && !empty;
  assign top_bit = {1'b0, pop_job.dist_a} >= pop_job.dist_sum;

  always_comb begin
    step[0] = '0;
    for (int s = 1; s < NSTG; s++) begin
      step[s] = div_step(rem[s-1], dvs[s-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], !empty};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Distance never exceeds the sum, so the top bit is set only when equal.
      rem[0]  <= top_bit ? ({1'b0, pop_job.dist_a} - pop_job.dist_sum)
                         : {1'b0, pop_job.dist_a};
      quo[0]  <= {top_bit, {(FRAC_W-1){1'b0}}};
      dvs[0]  <= pop_job.dist_sum;
      meta[0] <= pop_job.meta;
      for (int s = 1; s < NSTG; s++) begin
        rem[s]  <= step[s][SUM_W-1:0];
        quo[s]  <= quo[s-1] | (FRAC_W'(step[s][SUM_W]) << (NSTG - 1 - s));
        dvs[s]  <= dvs[s-1];
        meta[s] <= meta[s-1];
      end
    end
  end

  assign result_valid         = vld[NSTG-1];
  assign result.hit           = meta[NSTG-1].hit;
  assign result.first_corner  = meta[NSTG-1].first_corner;
  assign result.second_corner = meta[NSTG-1].second_corner;
  assign result.edge_fraction = quo[NSTG-1];
  assign result.last          = meta[NSTG-1].last;

endmodule

>>> src/hex_cell_isolevel_edge_crossings_top.sv
// Top level of the iso-level edge crossing block for one hexahedral cell.
//
//   channel  direction  handshake                 beat payload
//   item     in         item_valid / item_stall    cell_item_t: level and 8 corners
//   result   out        result_valid / result_stall edge_result_t: one crossed edge
//
// The front end takes one cell and issues one edge job per cycle while the queue has room:
// one per crossed edge, capped at six, or a single empty job when no edge is crossed.
// The next cell is taken in the same cycle that the last job of this one issues.
// Each job then passes a 17-stage divider pipe, one quotient bit per stage.
// rst is synchronous and clears handshake state only; payload registers keep garbage.
// A result_stall holds the whole divider pipe; the job queue lets the front run on
// until it fills, and then item_stall rises.
`timescale 1ns / 1ps
`include "hex_cell_isolevel_edge_crossings_top_defines.svh"
module hex_cell_isolevel_edge_crossings_top #(
  parameter int QUEUE_DEPTH = hcic_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  hcic_pkg::cell_item_t   item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output hcic_pkg::edge_result_t result
);
  import hcic_pkg::*;

  // Jobs flowing from the classifier into the queue.
  edge_job_t push_job;
  logic      push;
  logic      full;

  // Jobs flowing from the queue into the divider.
  edge_job_t pop_job;
  logic      pop;
  logic      empty;

  // Classify edges; issue one job per crossed edge, up to six, or one empty job.
  hcic_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .push       (push),
    .push_job   (push_job),
    .full       (full)
  );

  // Decouple the classifier from the divider so each can stall alone.
  hcic_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (empty)
  );

  // Form the fraction da * 2^16 / (da + db) and drive the result beat.
  hcic_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_job      (pop_job),
    .empty        (empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // A beat without a crossing always closes its cell.
  `HCIC_ASSERT_NOW(a_nohit_last, result_valid && !result.hit, result.last, "no-hit beat without last")

  // A crossing lies on the edge, never past its second corner.
  `HCIC_ASSERT_NOW(a_frac_range, result_valid && result.hit, result.edge_fraction <= FRAC_W'(65536), "fraction out of range")

  // A reported edge joins two distinct corners.
  `HCIC_ASSERT_NOW(a_edge_ends, result_valid && result.hit, result.first_corner != result.second_corner, "edge with equal corners")

  // A stalled result beat stays valid and unchanged.
  `HCIC_ASSERT_NEXT(a_hold_stalled, result_valid && result_stall, result_valid && $stable(result), "stalled beat changed")

endmodule

>>> tb/hex_cell_isolevel_edge_crossings_top_test.sv
// Self-checking testbench of the hex cell iso-level edge crossing block.
`timescale 1ns / 1ps
module hex_cell_isolevel_edge_crossings_top_test;
  import hcic_pkg::*;

  // Clock, reset and the block's ports. Every input is known from time zero.
  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         item_valid = 1'b0;
  logic         item_stall;
  cell_item_t   cell_beat = '0;
  logic         result_valid;
  logic         result_stall = 1'b0;
  edge_result_t edge_beat;

  // Cells waiting for the driver, and predicted result beats not yet seen.
  cell_item_t   pending_cells[$];
  edge_result_t expected_edges[$];

  // Cell edges in visiting order: first and second corner of each.
  int edge_from [NUM_EDGES] = '{0, 1, 3, 2, 4, 5, 7, 6, 0, 1, 2, 3};
  int edge_to   [NUM_EDGES] = '{1, 3, 2, 0, 5, 7, 6, 4, 4, 5, 6, 7};

  int corners [NUM_CORNERS];   // scratch corner values for the stimulus builder
  int cells_sent   = 0;
  int results_seen = 0;
  int mismatches   = 0;

  hex_cell_isolevel_edge_crossings_top uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (cell_beat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (edge_beat)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Work out the result beats of one cell and queue them in order.
  // An edge is crossed when exactly one end is at or above the level; the
  // fraction is da * 2^16 / (da + db), truncated. Only six crossings are
  // reported; a cell with none yields a single beat with hit clear.
  function automatic void predict_crossings(input cell_item_t c);
    int           vals [NUM_CORNERS];
    int           gap  [NUM_CORNERS];
    int           lvl;
    int           hits;
    int           a;
    int           b;
    longint       frac;
    edge_result_t held;
    edge_result_t r;
    lvl     = int'(c.iso_level);
    vals[0] = int'(c.corner_value_0);
    vals[1] = int'(c.corner_value_1);
    vals[2] = int'(c.corner_value_2);
    vals[3] = int'(c.corner_value_3);
    vals[4] = int'(c.corner_value_4);
    vals[5] = int'(c.corner_value_5);
    vals[6] = int'(c.corner_value_6);
    vals[7] = int'(c.corner_value_7);
    for (int k = 0; k < NUM_CORNERS; k++)
      gap[k] = (vals[k] >= lvl) ? vals[k] - lvl : lvl - vals[k];
    hits = 0;
    held = '0;
    for (int e = 0; e < NUM_EDGES && hits < MAX_HITS; e++) begin
      a = edge_from[e];
      b = edge_to[e];
      if ((vals[a] >= lvl) != (vals[b] >= lvl)) begin
        // Emit the previous crossing now that we know it is not the last one.
        if (hits > 0) expected_edges.push_back(held);
        frac = 0;
        if (gap[a] + gap[b] != 0)
          frac = (longint'(gap[a]) << 16) / longint'(gap[a] + gap[b]);
        r.hit           = 1'b1;
        r.first_corner  = CORNER_W'(a);
        r.second_corner = CORNER_W'(b);
        r.edge_fraction = FRAC_W'(frac);
        r.last          = 1'b0;
        held = r;
        hits++;
      end
    end
    if (hits == 0) begin
      held = '0;   // empty cell: hit, corners and fraction all zero
    end
    held.last = 1'b1;
    expected_edges.push_back(held);
  endfunction

  // Pack the scratch corners and a level into a cell and queue it.
  task automatic add_cell(input int lvl);
    cell_item_t c;
    c.iso_level      = VAL_W'(lvl);
    c.corner_value_0 = VAL_W'(corners[0]);
    c.corner_value_1 = VAL_W'(corners[1]);
    c.corner_value_2 = VAL_W'(corners[2]);
    c.corner_value_3 = VAL_W'(corners[3]);
    c.corner_value_4 = VAL_W'(corners[4]);
    c.corner_value_5 = VAL_W'(corners[5]);
    c.corner_value_6 = VAL_W'(corners[6]);
    c.corner_value_7 = VAL_W'(corners[7]);
    pending_cells.push_back(c);
  endtask

  function automatic int any_value();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int clamp_value(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Driver: present a cell, hold it while stalled, advance on acceptance.
  // The idle draw is skipped over a window of cells so that one stretch runs
  // back to back; at two points it holds off until every result is back.
  always @(posedge clk) begin
    cell_item_t nxt;
    bit         calm;
    bit         drain;
    bit         idle;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        predict_crossings(cell_beat);
        cells_sent++;
      end
      if (!item_valid || !item_stall) begin
        calm  = (cells_sent >= 140 && cells_sent < 200);
        drain = (cells_sent == 60 || cells_sent == 250) && expected_edges.size() != 0;
        idle  = !calm && ($urandom_range(0, 99) < 14);
        if (pending_cells.size() != 0 && !drain && !idle) begin
          nxt = pending_cells.pop_front();
          cell_beat  <= nxt;
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Monitor: compare each accepted result beat with the oldest prediction,
  // and stall the result side at random outside its own quiet window.
  always @(posedge clk) begin
    edge_result_t want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (expected_edges.size() == 0) begin
          $error("result beat with no prediction waiting: %h", edge_beat);
          mismatches++;
        end else begin
          want = expected_edges.pop_front();
          check_field("hit", want.hit, edge_beat.hit);
          check_field("first_corner", want.first_corner, edge_beat.first_corner);
          check_field("second_corner", want.second_corner, edge_beat.second_corner);
          check_field("edge_fraction", want.edge_fraction, edge_beat.edge_fraction);
          check_field("last", want.last, edge_beat.last);
        end
      end
      result_stall <= !(results_seen >= 300 && results_seen < 450) &&
                      ($urandom_range(0, 99) < 14);
    end
  end

  // Stimulus, then drain and final verdict.
  initial begin
    int lvl;
    int span;

    // Flat cell exactly at the level: nothing crosses.
    for (int k = 0; k < NUM_CORNERS; k++) corners[k] = 0;
    add_cell(0);
    // Floor level, corners at floor and at top: all at or above, no crossing.
    for (int k = 0; k < NUM_CORNERS; k++) corners[k] = -32768;
    add_cell(-32768);
    for (int k = 0; k < NUM_CORNERS; k++) corners[k] = 32767;
    add_cell(-32768);
    // Top level: all at it, then all below it.
    add_cell(32767);
    for (int k = 0; k < NUM_CORNERS; k++) corners[k] = -32768;
    add_cell(32767);
    // Corner 0 sits on the level: fraction 0 leaving it, full scale reaching it.
    corners[0] = 32767;
    add_cell(32767);
    // Corner 7 alone below a level one above the floor.
    for (int k = 0; k < NUM_CORNERS; k++) corners[k] = 32767;
    corners[7] = -32768;
    add_cell(-32767);
    // Checkerboard: every edge crossed, only six reported. Both polarities.
    for (int k = 0; k < NUM_CORNERS; k++)
      corners[k] = ($countones(k) % 2 != 0) ? 32767 : -32768;
    add_cell(0);
    for (int k = 0; k < NUM_CORNERS; k++)
      corners[k] = ($countones(k) % 2 != 0) ? -2 : 1;
    add_cell(-1);
    // Corners 0 and 7 up: exactly six crossings, no edge shared.
    for (int k = 0; k < NUM_CORNERS; k++) corners[k] = -5000;
    corners[0] = 7000;
    corners[7] = 123;
    add_cell(100);
    // Each corner alone above the level, random distances.
    for (int j = 0; j < NUM_CORNERS; j++) begin
      lvl = int'($urandom_range(0, 20000)) - 10000;
      for (int k = 0; k < NUM_CORNERS; k++)
        corners[k] = lvl - 1 - int'($urandom_range(0, 5000));
      corners[j] = lvl + int'($urandom_range(0, 5000));
      add_cell(lvl);
    end

    // Random cells: some over the whole range, most clustered round the level
    // so that the count of crossings and ties with the level vary widely.
    for (int n = 0; n < 320; n++) begin
      lvl = any_value();
      if ($urandom_range(0, 9) < 4) begin
        for (int k = 0; k < NUM_CORNERS; k++) corners[k] = any_value();
      end else begin
        case ($urandom_range(0, 2))
          0:       span = 4;
          1:       span = 64;
          default: span = 1024;
        endcase
        for (int k = 0; k < NUM_CORNERS; k++)
          corners[k] = clamp_value(lvl + int'($urandom_range(0, 2 * span)) - span);
      end
      add_cell(lvl);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Wait for every cell to go in and every predicted beat to come out,
    // then linger past the divider latency to catch stray beats.
    while (pending_cells.size() != 0 || item_valid || expected_edges.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
